/* sv/rrts_pkg.sv */
// ============================================================================
// Round-robin task scheduler package
// Field widths, operation codes, controller states and the command and
// status bundles passed between the controller and the datapath.
// ============================================================================
package rrts_pkg;

  // Fixed field widths of the input and result beats.
  localparam int unsigned OpW    = 1;
  localparam int unsigned DelayW = 32;
  localparam int unsigned RunW   = 3;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned TickW  = 32;

  // Operation codes carried by an input beat.
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 1'b0,
    OP_BLOCK = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAKE,
    ST_PICK
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // apply the accepted beat (tick or block)
    logic wake_step;  // check one wake-time entry
    logic pick;       // choose the next task and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wake_last;  // the wake sweep is at its last entry
  } dp_sts_t;

endpackage

/* sv/rrts_in_if.sv */
// ============================================================================
// Scheduler input channel
// Valid/ready channel that carries one operation beat.
// ============================================================================
interface rrts_in_if;
  import rrts_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [DelayW-1:0] delay_ticks;

  modport source (output valid, output operation, output delay_ticks, input ready);
  modport sink   (input valid, input operation, input delay_ticks, output ready);
endinterface

/* sv/rrts_out_if.sv */
// ============================================================================
// Scheduler result channel
// Valid/ready channel that carries one scheduling result beat.
// ============================================================================
interface rrts_out_if;
  import rrts_pkg::*;

  logic             valid;
  logic             ready;
  logic [RunW-1:0]  running_task;
  logic [MaskW-1:0] ready_mask;
  logic [TickW-1:0] tick_now;

  modport source (output valid, output running_task, output ready_mask,
                  output tick_now, input ready);
  modport sink   (input valid, input running_task, input ready_mask,
                  input tick_now, output ready);
endinterface

/* sv/round_robin_task_scheduler_top.sv */
// ============================================================================
// Round-robin task scheduler
// Each input beat is a timer tick or a request to block the running task
// for a number of ticks. The block handles one beat at a time. A block
// request goes from acceptance straight to the pick, which loads the
// result register; a tick first passes through the wake sweep, which
// compares one user task's wake time against the tick counter per
// cycle, and then reaches the pick. A new beat is accepted while a
// finished result still waits in the output register; the pick then
// holds until that register is free.
// Task 0 is the idle task; after reset task 1 runs and every user task is
// ready.
// ============================================================================
module round_robin_task_scheduler_top #(
  parameter int unsigned NUM_TASKS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rrts_in_if.sink           in_i,
  rrts_out_if.source        out_o
);
  import rrts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing and result handshake.
  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Task state and result payload.
  rrts_dp #(
    .NumTasks (NUM_TASKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (in_i.operation),
    .delay_i        (in_i.delay_ticks),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .running_task_o (out_o.running_task),
    .ready_mask_o   (out_o.ready_mask),
    .tick_now_o     (out_o.tick_now)
  );

endmodule

/* sv/rrts_ctrl.sv */
// ============================================================================
// Scheduler controller
// Sequences one beat at a time: apply, wake sweep on ticks, then the pick,
// and owns the valid flag of the result register.
// ============================================================================
module rrts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [rrts_pkg::OpW-1:0] in_op_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rrts_pkg::dp_cmd_t     cmd_o,
  input  rrts_pkg::dp_sts_t     sts_i
);
  import rrts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  // The result register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == OP_TICK) ? ST_WAKE : ST_PICK;
        end
      end
      ST_WAKE: begin
        if (sts_i.wake_last) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    cmd_o.exec      = accept;
    cmd_o.wake_step = (state_q == ST_WAKE);
    cmd_o.pick      = (state_q == ST_PICK) && slot_free;
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.pick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/rrts_dp.sv */
// ============================================================================
// Scheduler datapath
// Tick counter, per-task wake times and blocked flags, the round-robin
// pick and the result payload register.
// ============================================================================
module rrts_dp #(
  parameter int unsigned NumTasks = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rrts_pkg::OpW-1:0]    op_i,
  input  logic [rrts_pkg::DelayW-1:0] delay_i,
  input  rrts_pkg::dp_cmd_t           cmd_i,
  output rrts_pkg::dp_sts_t           sts_o,
  output logic [rrts_pkg::RunW-1:0]   running_task_o,
  output logic [rrts_pkg::MaskW-1:0]  ready_mask_o,
  output logic [rrts_pkg::TickW-1:0]  tick_now_o
);
  import rrts_pkg::*;

  localparam int unsigned UserTasks = NumTasks - 1;
  localparam int unsigned TaskW     = $clog2(NumTasks);
  localparam int unsigned IdxW      = (UserTasks > 1) ? $clog2(UserTasks) : 1;

  logic [TickW-1:0]     tick_q;
  logic [TickW-1:0]     wake_q [UserTasks];
  logic [UserTasks-1:0] blocked_q;
  logic [TaskW-1:0]     cur_q;
  logic [IdxW-1:0]      idx_q;
  logic [RunW-1:0]      run_q;
  logic [MaskW-1:0]     mask_q;
  logic [TickW-1:0]     tick_out_q;

  logic [IdxW-1:0]        wr_idx;
  logic                   blk_en;
  logic [TaskW-1:0]       next_task;
  logic [RunW+TaskW-1:0]  run_ext;
  logic [MaskW+UserTasks-1:0] mask_ext;

  // Blocked flag of user task t sits at entry t-1.
  assign wr_idx = IdxW'(cur_q - TaskW'(1));
  assign blk_en = cmd_i.exec && (op_i == OP_BLOCK) && (cur_q != '0);

  assign sts_o.wake_last = (idx_q == IdxW'(UserTasks - 1));

  // Round-robin pick: start after the current task, current task last,
  // idle task when no user task is ready. Smaller offsets win.
  always_comb begin
    logic [TaskW:0] base_w;
    logic [TaskW:0] sum_w;
    next_task = '0;
    if (cur_q == '0) begin
      base_w = (TaskW+1)'(UserTasks - 1);
    end else begin
      base_w = {1'b0, cur_q} - (TaskW+1)'(1);
    end
    for (int k = UserTasks; k >= 1; k--) begin
      sum_w = base_w + (TaskW+1)'(k);
      if (sum_w >= (TaskW+1)'(UserTasks)) begin
        sum_w = sum_w - (TaskW+1)'(UserTasks);
      end
      if (!blocked_q[IdxW'(sum_w)]) begin
        next_task = TaskW'(sum_w) + TaskW'(1);
      end
    end
  end

  // Control state: counter, blocked flags, current task, sweep index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      blocked_q <= '0;
      cur_q     <= TaskW'(1);
      idx_q     <= '0;
    end else begin
      if (cmd_i.exec && (op_i == OP_TICK)) begin
        tick_q <= tick_q + TickW'(1);
        idx_q  <= '0;
      end
      if (blk_en) begin
        blocked_q[wr_idx] <= 1'b1;
      end
      if (cmd_i.wake_step) begin
        if (blocked_q[idx_q] && (wake_q[idx_q] <= tick_q)) begin
          blocked_q[idx_q] <= 1'b0;
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.pick) begin
        cur_q <= next_task;
      end
    end
  end

  // Wake times are only read for blocked tasks, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (blk_en) begin
      wake_q[wr_idx] <= tick_q + delay_i;
    end
  end

  // Result payload register.
  assign run_ext  = {{RunW{1'b0}}, next_task};
  assign mask_ext = {{MaskW{1'b0}}, ~blocked_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      run_q      <= run_ext[RunW-1:0];
      mask_q     <= mask_ext[MaskW-1:0];
      tick_out_q <= tick_q;
    end
  end

  assign running_task_o = run_q;
  assign ready_mask_o   = mask_q;
  assign tick_now_o     = tick_out_q;

endmodule

/* test/round_robin_task_scheduler_top_tb.sv */
// ============================================================================
// Round-robin task scheduler testbench
// Drives tick and block beats into the scheduler and checks every result
// beat against a behavioral predictor of the tick counter, the per-task
// wake times and blocked flags, and the round-robin pick. A short directed
// sequence covers zero delay, wrapped wake times, the case where only the
// running task is ready, and idle, including a block request while idle.
// Random traffic follows, with random gaps on both channels.
// ============================================================================
module round_robin_task_scheduler_top_tb;
  import rrts_pkg::*;

  localparam int unsigned NumTasks    = 5;
  localparam int unsigned RandBeats   = 500;
  localparam int unsigned ChunkBeats  = 50;
  localparam int unsigned MaxGap      = 11;
  localparam int unsigned DrainCycles = NumTasks + 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxPrinted  = 40;

  // One expected result beat.
  typedef struct packed {
    logic [RunW-1:0]  run;
    logic [MaskW-1:0] mask;
    logic [TickW-1:0] tick;
  } sched_result_t;

  // Predicts the scheduler state and checks result beats in order.
  class sched_scoreboard;
    bit [TickW-1:0] tick_count;
    bit [TickW-1:0] wake_at [NumTasks];
    bit             blocked [NumTasks];
    int unsigned    cur_task;
    sched_result_t  pending [$];
    int unsigned    n_errors;

    function new();
      tick_count = '0;
      foreach (wake_at[t]) begin
        wake_at[t] = '0;
        blocked[t] = 1'b0;
      end
      cur_task = 1;
      n_errors = 0;
    endfunction

    // Round-robin over the user tasks, starting after the current one and
    // trying the current one last; idle when nothing is ready.
    function void pick_next_task();
      int unsigned pos;
      int unsigned cand;
      pos = (cur_task == 0) ? NumTasks - 1 : cur_task;
      for (int unsigned k = 1; k < NumTasks; k++) begin
        cand = (pos - 1 + k) % (NumTasks - 1) + 1;
        if (!blocked[cand]) begin
          cur_task = cand;
          return;
        end
      end
      cur_task = 0;
    endfunction

    // Applies one accepted input beat and queues the result it causes.
    function void note_beat(op_e op, logic [DelayW-1:0] delay);
      sched_result_t want;
      logic [MaskW-1:0] mask;
      if (cur_task >= NumTasks) cur_task = 0;
      if (op == OP_TICK) begin
        tick_count = tick_count + 1'b1;
        for (int unsigned t = 1; t < NumTasks; t++) begin
          if (blocked[t] && wake_at[t] <= tick_count) blocked[t] = 1'b0;
        end
      end else if (cur_task != 0) begin
        wake_at[cur_task] = tick_count + delay;
        blocked[cur_task] = 1'b1;
      end
      pick_next_task();
      mask = '0;
      for (int unsigned t = 1; t < NumTasks; t++) begin
        if (!blocked[t] && t - 1 < MaskW) mask[t-1] = 1'b1;
      end
      want.run  = cur_task[RunW-1:0];
      want.mask = mask;
      want.tick = tick_count;
      pending.push_back(want);
    endfunction

    task report_mismatch(string what);
      n_errors++;
      if (n_errors <= MaxPrinted) $display("mismatch: %s", what);
    endtask

    // Compares one result beat with the oldest expectation.
    task check_result(logic [RunW-1:0] run, logic [MaskW-1:0] mask,
                      logic [TickW-1:0] tick);
      sched_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: run %0d mask %h tick %0d",
                                  run, mask, tick));
      end else begin
        want = pending.pop_front();
        if (run !== want.run)
          report_mismatch($sformatf("running_task %0d, expected %0d at tick %0d",
                                    run, want.run, want.tick));
        if (mask !== want.mask)
          report_mismatch($sformatf("ready_mask %h, expected %h at tick %0d",
                                    mask, want.mask, want.tick));
        if (tick !== want.tick)
          report_mismatch($sformatf("tick_now %0d, expected %0d", tick, want.tick));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b1;
  int unsigned cycles = 0;
  sched_scoreboard sb;

  rrts_in_if  in_if ();
  rrts_out_if out_if ();

  round_robin_task_scheduler_top #(
    .NUM_TASKS(NumTasks)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Beat monitor: results are checked before the new input beat is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.running_task, out_if.ready_mask, out_if.tick_now);
      if (in_if.valid && in_if.ready)
        sb.note_beat(op_e'(in_if.operation), in_if.delay_ticks);
    end
  end

  // Result side: random stalls before each beat.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Sends one input beat after a random gap and waits for acceptance.
  task automatic send_beat(op_e op, logic [DelayW-1:0] delay);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.delay_ticks <= delay;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    op_e              op;
    logic [DelayW-1:0] delay;
    int unsigned      tick_pct;
    int unsigned      sel;
    int unsigned      back;
    int unsigned      n_huge;
    sb = new();
    n_huge = 0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.operation   <= OP_TICK;
    in_if.delay_ticks <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: ignored delay on a tick, zero delay, a wake time that
    // wraps below the counter, only the running task ready, then idle.
    send_beat(OP_TICK, 32'hFFFF_FFFF);
    send_beat(OP_BLOCK, 32'h0000_0000);
    send_beat(OP_TICK, 32'h0000_0000);
    send_beat(OP_BLOCK, 32'hFFFF_FFFF);
    send_beat(OP_TICK, 32'h0000_0000);
    repeat (3) send_beat(OP_BLOCK, 32'd5);
    send_beat(OP_TICK, 32'h0000_0000);
    send_beat(OP_BLOCK, 32'd3);
    send_beat(OP_BLOCK, 32'hA5A5_5A5A);
    repeat (6) send_beat(OP_TICK, 32'h0000_0000);
    send_beat(OP_BLOCK, 32'd1);
    send_beat(OP_TICK, 32'h5A5A_A5A5);
    send_beat(OP_TICK, 32'h0000_0000);

    // Random part, in chunks with their own idling and tick rate. Block
    // delays are mostly short so that tasks keep waking; a few wrap below
    // the counter and at most two are fully random.
    for (int unsigned i = 0; i < RandBeats; i++) begin
      if (i % ChunkBeats == 0) begin
        idle_on  = ($urandom_range(0, 2) != 0);
        tick_pct = $urandom_range(30, 70);
      end
      op  = ($urandom_range(1, 100) <= tick_pct) ? OP_TICK : OP_BLOCK;
      sel = $urandom_range(1, 100);
      if (op == OP_TICK) begin
        delay = $urandom();
      end else if (sel <= 65) begin
        delay = $urandom_range(0, 12);
      end else if (sel <= 85) begin
        back  = (sb.tick_count < 20) ? sb.tick_count : 20;
        delay = '0 - DelayW'($urandom_range(0, back));
      end else if (sel <= 98 || n_huge >= 2) begin
        delay = $urandom_range(13, 200);
      end else begin
        delay = $urandom();
        n_huge++;
      end
      send_beat(op, delay);
    end
    in_if.valid <= 1'b0;

    // Drain the outstanding results, then watch for stray beats.
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/rrts_pkg.sv
sv/rrts_in_if.sv
sv/rrts_out_if.sv
sv/rrts_ctrl.sv
sv/rrts_dp.sv
sv/round_robin_task_scheduler_top.sv
test/round_robin_task_scheduler_top_tb.sv
